@@ src/tcw_pkg.sv @@
// shared types and constants for the text console writer
// no dependencies; imported by every module of the block
package tcw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam int FUNC_W   = 2;
  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 11;
  localparam int CURCOL_W = 7;
  localparam int CURROW_W = 5;
  localparam int CELL_DW  = 16;
  localparam int CFG_DW   = 8;
  localparam int CFG_IW   = 1;

  // function codes
  localparam logic [FUNC_W-1:0] FN_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd2;

  // control characters
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;

  // register indexes
  localparam logic [CFG_IW-1:0] CFG_TEXT_ATTR  = 1'd0;
  localparam logic [CFG_IW-1:0] CFG_PROMPT_LEN = 1'd1;

  localparam logic [7:0] ATTR_RESET   = 8'd7;
  localparam logic [6:0] PROMPT_RESET = 7'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [CHAR_W-1:0]  char_code;
    logic [INDEX_W-1:0] cell_index;
  } tcw_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0]   cell_char;
    logic [CHAR_W-1:0]   cell_attr;
    logic [CURCOL_W-1:0] cursor_col;
    logic [CURROW_W-1:0] cursor_row;
  } tcw_out_t;

  typedef struct packed {
    logic [7:0] text_attribute;
    logic [6:0] prompt_length;
  } tcw_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_SCROLL,
    ST_BLANK,
    ST_PEND
  } tcw_state_t;

endpackage

@@ src/text_console_writer_core.sv @@
// text console writer top level: configuration registers, sequencer, screen memory
// depends on tcw_pkg, tcw_ctrl and tcw_screen_ram
//
// channel   direction  handshake                     payload
// command   in         start & !busy                 cmd    (tcw_in_t)
// result    out        done, one cycle, no stall     result (tcw_out_t)
// config    in         cfg_we                        cfg_index, cfg_data
//
// put of an ordinary character, newline, return or backspace: result in the
//   cycle after the beat, and the next beat can be taken in that same cycle
// read: the result follows the registered read of the screen memory
// clear, and a put that leaves the last row: the screen memory is swept one
//   cell a cycle, busy throughout
// reset: a clearing pass over all COLUMNS*ROWS cells blanks the memory; busy is
//   high until it ends and no result is given for it
// the receiver cannot stall; every result is on the ports for one cycle
module text_console_writer_core
  import tcw_pkg::*;
#(
  parameter int SCREEN_COLUMNS = DEF_COLUMNS,
  parameter int SCREEN_ROWS    = DEF_ROWS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tcw_in_t           cmd,
  output logic              done,
  output tcw_out_t          result,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int AW    = $clog2(CELLS);

  tcw_cfg_t           cfg;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [CELL_DW-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [CELL_DW-1:0] mem_rdata;

  // configuration registers; the user must write them only while the block is quiet, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.text_attribute <= ATTR_RESET;
      cfg.prompt_length  <= PROMPT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEXT_ATTR:  cfg.text_attribute <= cfg_data;
        CFG_PROMPT_LEN: cfg.prompt_length  <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer: cursor state, command decode, scroll and clear sweeps
  tcw_ctrl #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS),
    .AW             (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .cfg       (cfg),
    .done      (done),
    .result    (result),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // character in the low byte, attribute in the high byte
  tcw_screen_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

@@ src/tcw_screen_ram.sv @@
// screen cell memory: one write port, one read port, registered read data
// depends on tcw_pkg for the cell width
module tcw_screen_ram
  import tcw_pkg::*;
#(
  parameter int DEPTH = DEF_COLUMNS * DEF_ROWS,
  parameter int AW    = $clog2(DEF_COLUMNS * DEF_ROWS)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [CELL_DW-1:0] wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output logic [CELL_DW-1:0] rdata
);

  logic [CELL_DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/tcw_ctrl.sv @@
// command sequencer: cursor, put/read/clear handling, scroll and clear sweeps
// depends on tcw_pkg; drives the ports of tcw_screen_ram
module tcw_ctrl
  import tcw_pkg::*;
#(
  parameter int SCREEN_COLUMNS = DEF_COLUMNS,
  parameter int SCREEN_ROWS    = DEF_ROWS,
  parameter int AW             = $clog2(DEF_COLUMNS * DEF_ROWS)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  tcw_in_t            cmd,
  input  tcw_cfg_t           cfg,
  output logic               done,
  output tcw_out_t           result,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output logic [CELL_DW-1:0] mem_wdata,
  output logic               mem_re,
  output logic [AW-1:0]      mem_raddr,
  input  logic [CELL_DW-1:0] mem_rdata
);

  localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int COL_W = $clog2(SCREEN_COLUMNS + 1);
  localparam int ROW_W = $clog2(SCREEN_ROWS);
  localparam int CMP_W = (COL_W > 7) ? COL_W : 7;
  localparam int IDX_CMP_W = 16;

  localparam logic [AW-1:0]    LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0]    ROW_CELLS = AW'(SCREEN_COLUMNS);
  localparam logic [AW-1:0]    LAST_ROW_BASE = AW'(CELLS - SCREEN_COLUMNS);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_ROWS - 1);
  localparam logic [COL_W-1:0] FULL_COL = COL_W'(SCREEN_COLUMNS);

  tcw_state_t state, state_next;
  logic [AW-1:0]      ctr, ctr_next;
  logic               cp_valid, cp_valid_next;
  logic [AW-1:0]      cp_dst, cp_dst_next;
  logic [COL_W-1:0]   cur_col, cur_col_next;
  logic [ROW_W-1:0]   cur_row, cur_row_next;
  logic               clr_emit, clr_emit_next;
  logic               pend, pend_next;
  logic [CELL_DW-1:0] pend_data, pend_data_next;
  logic               rd_zero, rd_zero_next;
  logic               done_next;
  tcw_out_t           result_next;

  logic               accept;
  logic               last_row;
  logic               line_full;
  logic [COL_W-1:0]   bs_col;
  logic [COL_W-1:0]   wa_col;
  logic [ROW_W-1:0]   wa_row;
  logic [AW-1:0]      put_addr;
  logic               idx_ok;
  logic [CHAR_W-1:0]  res_char, res_attr;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign last_row  = (cur_row == LAST_ROW);
  assign line_full = (cur_col >= FULL_COL);
  assign idx_ok    = (IDX_CMP_W'(cmd.cell_index) < IDX_CMP_W'(CELLS));

  // backspace target column and the cell a put touches
  always_comb begin
    bs_col = (CMP_W'(cur_col) > CMP_W'(cfg.prompt_length)) ? cur_col - COL_W'(1) : cur_col;
    if (cmd.char_code == CH_BACKSPACE) begin
      wa_col = bs_col;
      wa_row = cur_row;
    end else if (line_full) begin
      wa_col = '0;
      wa_row = cur_row + ROW_W'(1);
    end else begin
      wa_col = cur_col;
      wa_row = cur_row;
    end
  end

  assign put_addr = AW'(wa_row * SCREEN_COLUMNS) + AW'(wa_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      ctr      <= '0;
      cp_valid <= 1'b0;
      cur_col  <= '0;
      cur_row  <= '0;
      clr_emit <= 1'b0;
      pend     <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      ctr      <= ctr_next;
      cp_valid <= cp_valid_next;
      cur_col  <= cur_col_next;
      cur_row  <= cur_row_next;
      clr_emit <= clr_emit_next;
      pend     <= pend_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cp_dst    <= cp_dst_next;
    pend_data <= pend_data_next;
    rd_zero   <= rd_zero_next;
    if (done_next) begin
      result <= result_next;
    end
  end

  always_comb begin
    state_next     = state;
    ctr_next       = ctr;
    cp_valid_next  = cp_valid;
    cp_dst_next    = cp_dst;
    cur_col_next   = cur_col;
    cur_row_next   = cur_row;
    clr_emit_next  = clr_emit;
    pend_next      = pend;
    pend_data_next = pend_data;
    rd_zero_next   = rd_zero;
    done_next      = 1'b0;
    res_char       = '0;
    res_attr       = '0;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd.func)
            FN_PUT: begin
              if (cmd.char_code inside {CH_NEWLINE, CH_RETURN}) begin
                cur_col_next = '0;
                if (last_row) begin
                  state_next    = ST_SCROLL;
                  ctr_next      = ROW_CELLS;
                  cp_valid_next = 1'b0;
                  pend_next     = 1'b0;
                end else begin
                  cur_row_next = cur_row + ROW_W'(1);
                  done_next    = 1'b1;
                end
              end else if (cmd.char_code == CH_BACKSPACE) begin
                cur_col_next = bs_col;
                if (bs_col < FULL_COL) begin
                  mem_we    = 1'b1;
                  mem_waddr = put_addr;
                  mem_wdata = {cfg.text_attribute, 8'h00};
                end
                done_next = 1'b1;
              end else if (line_full && last_row) begin
                // wrap off the bottom: scroll first, then store the character
                state_next     = ST_SCROLL;
                ctr_next       = ROW_CELLS;
                cp_valid_next  = 1'b0;
                pend_next      = 1'b1;
                pend_data_next = {cfg.text_attribute, cmd.char_code};
                cur_col_next   = COL_W'(1);
              end else begin
                mem_we       = 1'b1;
                mem_waddr    = put_addr;
                mem_wdata    = {cfg.text_attribute, cmd.char_code};
                cur_row_next = wa_row;
                cur_col_next = wa_col + COL_W'(1);
                done_next    = 1'b1;
              end
            end
            FN_READ: begin
              mem_re       = idx_ok;
              mem_raddr    = AW'(cmd.cell_index);
              rd_zero_next = !idx_ok;
              state_next   = ST_READ;
            end
            FN_CLEAR: begin
              state_next    = ST_CLEAR;
              ctr_next      = '0;
              clr_emit_next = 1'b1;
              cur_col_next  = '0;
              cur_row_next  = '0;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        if (!rd_zero) begin
          res_char = mem_rdata[7:0];
          res_attr = mem_rdata[15:8];
        end
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ctr;
        if (ctr == LAST_CELL) begin
          state_next    = ST_IDLE;
          done_next     = clr_emit;
          clr_emit_next = 1'b0;
        end else begin
          ctr_next = ctr + AW'(1);
        end
      end
      ST_SCROLL: begin
        // read one row ahead, write the cell a row up in the next cycle
        mem_re        = 1'b1;
        mem_raddr     = ctr;
        cp_valid_next = 1'b1;
        cp_dst_next   = ctr - ROW_CELLS;
        if (cp_valid) begin
          mem_we    = 1'b1;
          mem_waddr = cp_dst;
          mem_wdata = mem_rdata;
        end
        cur_col_next = cur_col;
        cur_row_next = LAST_ROW;
        if (ctr == LAST_CELL) begin
          state_next = ST_BLANK;
          ctr_next   = LAST_ROW_BASE;
        end else begin
          ctr_next = ctr + AW'(1);
        end
      end
      ST_BLANK: begin
        cp_valid_next = 1'b0;
        mem_we        = 1'b1;
        if (cp_valid) begin
          mem_waddr = cp_dst;
          mem_wdata = mem_rdata;
        end else begin
          mem_waddr = ctr;
          if (ctr == LAST_CELL) begin
            if (pend) begin
              state_next = ST_PEND;
            end else begin
              state_next = ST_IDLE;
              done_next  = 1'b1;
            end
          end else begin
            ctr_next = ctr + AW'(1);
          end
        end
      end
      ST_PEND: begin
        mem_we     = 1'b1;
        mem_waddr  = LAST_ROW_BASE;
        mem_wdata  = pend_data;
        pend_next  = 1'b0;
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    result_next.cell_char  = res_char;
    result_next.cell_attr  = res_attr;
    result_next.cursor_col = CURCOL_W'(cur_col_next);
    result_next.cursor_row = CURROW_W'(cur_row_next);
  end

  // cursor stays on the screen
  assert property (@(posedge clk) disable iff (rst) cur_row <= LAST_ROW)
    else $error("cursor row off screen");

  assert property (@(posedge clk) disable iff (rst) cur_col <= FULL_COL)
    else $error("cursor column past line end");

  // copy writes trail the reads so no cell is overwritten before it is read
  assert property (@(posedge clk) disable iff (rst)
      (state == ST_SCROLL && cp_valid) |-> (cp_dst < ctr))
    else $error("scroll copy overtook its read");

  // the last copy write drains in the first blanking cycle
  assert property (@(posedge clk) disable iff (rst)
      (state == ST_BLANK && cp_valid) |=> !cp_valid)
    else $error("copy pipeline not drained");

  assert property (@(posedge clk) disable iff (rst)
      (accept && cmd.func == FN_READ) |=> (state == ST_READ && !busy == 1'b0))
    else $error("read did not enter the read wait");

endmodule

@@ dv/text_console_writer_checker.sv @@
`timescale 1ns / 1ps
// result checker for text_console_writer_core: keeps its own screen, cursor and registers
// and predicts every result beat from the command and config beats; depends on tcw_pkg
module text_console_writer_checker
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  tcw_in_t           cmd,
  input  logic              done,
  input  tcw_out_t          result,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  output int                outstanding,
  output int                fail_count
);

  localparam int COLS  = DEF_COLUMNS;
  localparam int ROWS  = DEF_ROWS;
  localparam int CELLS = COLS * ROWS;

  logic [CELL_DW-1:0] screen [CELLS];
  int unsigned        col_pos;
  int unsigned        row_pos;
  logic [7:0]         attr_val;
  logic [6:0]         prompt_val;
  tcw_out_t           expected_q[$];
  int                 mismatches = 0;
  int                 result_no  = 0;

  function automatic void shift_rows_up();
    for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
    for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = '0;
    col_pos = 0;
    row_pos = ROWS - 1;
  endfunction

  function automatic void next_row();
    col_pos = 0;
    row_pos++;
    if (row_pos >= ROWS) shift_rows_up();
  endfunction

  // nothing is stored while the cursor sits past the last column
  function automatic void store_cell(logic [CHAR_W-1:0] ch);
    if (col_pos < COLS && row_pos < ROWS) screen[row_pos * COLS + col_pos] = {attr_val, ch};
  endfunction

  function automatic tcw_out_t console_step(tcw_in_t c);
    tcw_out_t r;
    r = '0;
    case (c.func)
      FN_PUT: begin
        if (c.char_code == CH_NEWLINE || c.char_code == CH_RETURN) begin
          next_row();
        end else begin
          if (row_pos >= ROWS) shift_rows_up();
          if (c.char_code == CH_BACKSPACE) begin
            if (col_pos > prompt_val) col_pos--;
            store_cell('0);
          end else begin
            // full line: wrap first, then write
            if (col_pos >= COLS) next_row();
            store_cell(c.char_code);
            col_pos++;
          end
        end
      end
      FN_READ: begin
        if (c.cell_index < CELLS) {r.cell_attr, r.cell_char} = screen[c.cell_index];
      end
      FN_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen[i] = '0;
        col_pos = 0;
        row_pos = 0;
      end
      default: ;
    endcase
    r.cursor_col = CURCOL_W'(col_pos);
    r.cursor_row = CURROW_W'(row_pos);
    return r;
  endfunction

  function automatic void flag(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t mismatch: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin
    tcw_out_t want;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) screen[i] = '0;
      col_pos    = 0;
      row_pos    = 0;
      attr_val   = ATTR_RESET;
      prompt_val = PROMPT_RESET;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TEXT_ATTR:  attr_val = cfg_data;
          CFG_PROMPT_LEN: prompt_val = cfg_data[6:0];
          default: ;
        endcase
      end
      if (done) begin
        result_no++;
        if (expected_q.size() == 0) begin
          flag($sformatf("result %0d with nothing expected: char %02h attr %02h col %0d row %0d",
                         result_no, result.cell_char, result.cell_attr,
                         result.cursor_col, result.cursor_row));
        end else begin
          want = expected_q.pop_front();
          if (result.cell_char !== want.cell_char || result.cell_attr !== want.cell_attr ||
              result.cursor_col !== want.cursor_col || result.cursor_row !== want.cursor_row)
            flag($sformatf({"result %0d: expected char %02h attr %02h col %0d row %0d,",
                            " got char %02h attr %02h col %0d row %0d"},
                           result_no, want.cell_char, want.cell_attr, want.cursor_col,
                           want.cursor_row, result.cell_char, result.cell_attr,
                           result.cursor_col, result.cursor_row));
        end
      end
      if (start && !busy) expected_q.push_back(console_step(cmd));
    end
    outstanding <= expected_q.size();
    fail_count  <= mismatches;
  end

endmodule

@@ dv/text_console_writer_core_tb.sv @@
`timescale 1ns / 1ps
// top of the text_console_writer_core testbench: clock, reset, command and config stimulus
// and the verdict; depends on tcw_pkg, text_console_writer_core, text_console_writer_checker
module text_console_writer_core_tb;
  import tcw_pkg::*;

  localparam int CELLS = DEF_COLUMNS * DEF_ROWS;
  // func code the block leaves unused
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  // per beat: a full sweep of the screen plus slack, taken four times over
  localparam int CYCLE_LIMIT = 4 * 1800 * (CELLS + 64) + 4 * CELLS;
  localparam int PHASE_BEATS = 290;

  logic                clk;
  logic                rst       = 1'b1;
  logic                start     = 1'b0;
  tcw_in_t             cmd       = '0;
  logic                cfg_we    = 1'b0;
  logic [CFG_IW-1:0]   cfg_index = '0;
  logic [CFG_DW-1:0]   cfg_data  = '0;
  logic                busy;
  logic                done;
  tcw_out_t            result;
  int                  outstanding;
  int                  fail_count;
  int                  sent   = 0;
  int                  cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  text_console_writer_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  text_console_writer_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .done        (done),
    .result      (result),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  // hang guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL text_console_writer_core");
      $finish;
    end
  end

  // drop start and hold off until every result is in and the block is idle;
  // it first waits on the clock so that the count already covers the last accepted beat
  task automatic wait_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
  endtask

  // one command beat; busy is read just after the edge, so it is the value the dut saw
  task automatic issue(logic [FUNC_W-1:0] f, logic [CHAR_W-1:0] ch, logic [INDEX_W-1:0] ix);
    // every 500 beats a run of 120 goes out back to back
    if ((sent % 500) >= 120) begin
      while ($urandom_range(0, 99) < 23) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    cmd   <= '{func: f, char_code: ch, cell_index: ix};
    do @(posedge clk); while (busy);
    sent++;
    // now and then let the block drain completely mid-stream
    if ($urandom_range(0, 199) == 0) wait_quiet();
  endtask

  // both registers, one write each on consecutive edges
  task automatic write_regs(logic [7:0] attr, logic [6:0] prompt);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TEXT_ATTR;
    cfg_data  <= attr;
    @(posedge clk);
    cfg_index <= CFG_PROMPT_LEN;
    cfg_data  <= {1'b0, prompt};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int phase_end;
    int pick;
    int len;
    int tail;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // the block blanks its memory after reset; give busy time to show up
    repeat (4) @(posedge clk);
    wait_quiet();
    write_regs(ATTR_RESET, PROMPT_RESET);

    // directed: blank reads, corners of the index, prompt guard, control chars
    issue(FN_READ, 8'h00, 11'd0);
    issue(FN_READ, 8'hff, 11'(CELLS - 1));
    issue(FN_READ, 8'h00, 11'(CELLS));           // first index past the screen
    issue(FN_READ, 8'hff, 11'h7ff);
    issue(FN_PUT, CH_BACKSPACE, 11'd0);          // at column 0, guard holds, blank written
    issue(FN_PUT, 8'h00, 11'h7ff);
    issue(FN_PUT, 8'hff, 11'd0);
    issue(FN_PUT, 8'h41, 11'd0);
    issue(FN_PUT, CH_BACKSPACE, 11'd0);          // steps back onto the prompt edge
    issue(FN_PUT, CH_BACKSPACE, 11'd0);          // at the prompt edge, cursor stays
    issue(FN_READ, 8'h00, 11'd1);
    issue(FN_READ, 8'h00, 11'd2);
    issue(FN_PUT, CH_NEWLINE, 11'd0);
    issue(FN_PUT, CH_RETURN, 11'd0);
    issue(FN_PUT, 8'h7e, 11'd0);
    issue(FN_READ, 8'h00, 11'(2 * DEF_COLUMNS));
    issue(FN_UNUSED, 8'hff, 11'h7ff);
    issue(FN_CLEAR, 8'hff, 11'h7ff);
    issue(FN_READ, 8'h00, 11'd0);

    for (int phase = 0; phase < 6; phase++) begin
      // registers only change with the block drained
      wait_quiet();
      case (phase)
        0:       write_regs(8'h00, 7'd0);
        1:       write_regs(8'hff, 7'(DEF_COLUMNS));    // backspace never steps
        2:       write_regs(8'($urandom), 7'(DEF_COLUMNS - 1));
        3:       write_regs(8'($urandom), 7'($urandom_range(0, DEF_COLUMNS)));
        4:       write_regs(8'($urandom), 7'd1);
        default: write_regs(8'($urandom), 7'($urandom_range(0, DEF_COLUMNS)));
      endcase
      phase_end = sent + PHASE_BEATS;
      while (sent < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 66) begin
          // a line of text; about one in four runs to or past the full line
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(76, 84) : $urandom_range(0, 30);
          repeat (len) issue(FN_PUT, 8'($urandom), 11'($urandom));
          tail = $urandom_range(0, 9);
          if (tail < 5) issue(FN_PUT, CH_NEWLINE, 11'($urandom));
          else if (tail < 7) issue(FN_PUT, CH_RETURN, 11'($urandom));
          else if (tail < 9) repeat ($urandom_range(1, 6)) issue(FN_PUT, CH_BACKSPACE, 11'($urandom));
          // else the line runs on into the next one
        end else if (pick < 72) begin
          // backspace burst to run into the prompt guard
          repeat ($urandom_range(1, 12)) issue(FN_PUT, CH_BACKSPACE, 11'($urandom));
        end else if (pick < 88) begin
          // reads, some of them past the last cell
          repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(0, 3) == 0)
              issue(FN_READ, 8'($urandom), 11'($urandom_range(CELLS - 10, 2047)));
            else
              issue(FN_READ, 8'($urandom), 11'($urandom_range(0, CELLS - 1)));
          end
        end else if (pick < 90) begin
          issue(FN_CLEAR, 8'($urandom), 11'($urandom));
        end else if (pick < 94) begin
          issue(FN_UNUSED, 8'($urandom), 11'($urandom));
        end else begin
          // noise: any func, any fields
          issue(2'($urandom), 8'($urandom), 11'($urandom));
        end
      end
    end

    wait_quiet();
    // catch any stray result after the last one
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS text_console_writer_core");
    end else begin
      $display("FAIL text_console_writer_core");
    end
    $finish;
  end

endmodule

@@ text_console_writer_core.f @@
src/tcw_pkg.sv
src/tcw_screen_ram.sv
src/tcw_ctrl.sv
src/text_console_writer_core.sv
dv/text_console_writer_checker.sv
dv/text_console_writer_core_tb.sv
